// ----- src/line_command_matcher_assert.svh -----
// assertion helpers for line_command_matcher
`ifndef LINE_COMMAND_MATCHER_ASSERT_SVH
`define LINE_COMMAND_MATCHER_ASSERT_SVH

// same-cycle implication
`define LCM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lcm_pkg.sv -----
package lcm_pkg;

    localparam int WORD_COUNT = 8;
    localparam int WORD_SLOTS = 8;
    localparam int CMD_W      = 3;

    // command words, already folded to lower case
    localparam logic [7:0] WORD_TEXT [WORD_COUNT][WORD_SLOTS] = '{
        '{8'h6c, 8'h65, 8'h64, 8'h31, 8'h6f, 8'h6e, 8'h00, 8'h00},
        '{8'h6c, 8'h65, 8'h64, 8'h31, 8'h6f, 8'h66, 8'h66, 8'h00},
        '{8'h6c, 8'h65, 8'h64, 8'h32, 8'h6f, 8'h6e, 8'h00, 8'h00},
        '{8'h6c, 8'h65, 8'h64, 8'h32, 8'h6f, 8'h66, 8'h66, 8'h00},
        '{8'h61, 8'h6c, 8'h6c, 8'h6f, 8'h6e, 8'h00, 8'h00, 8'h00},
        '{8'h61, 8'h6c, 8'h6c, 8'h6f, 8'h66, 8'h66, 8'h00, 8'h00},
        '{8'h68, 8'h65, 8'h6c, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h64, 8'h69, 8'h73, 8'h74, 8'h3f, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
        4'd6, 4'd7, 4'd6, 4'd7, 4'd5, 4'd6, 4'd4, 4'd5
    };

    localparam logic [1:0] ST_BUSY     = 2'd0;
    localparam logic [1:0] ST_FRAME    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    typedef enum logic [2:0] {
        KIND_CR,
        KIND_LF,
        KIND_BLANK,
        KIND_ZERO,
        KIND_TEXT
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CMD_W-1:0] command;
    } result_t;

endpackage

// ----- src/lcm_classify.sv -----
module lcm_classify (
    input  logic           [7:0] rx_byte,
    output lcm_pkg::item_t       item
);
    import lcm_pkg::*;

    always_comb
    begin
        item.ch = rx_byte;
        if (rx_byte >= 8'h41 && rx_byte <= 8'h5a)
        begin
            item.ch = rx_byte + 8'h20;
        end
        unique case (rx_byte)
            CH_CR:                             item.kind = KIND_CR;
            CH_LF:                             item.kind = KIND_LF;
            8'h20, 8'h09, 8'h0b, 8'h0c:        item.kind = KIND_BLANK;
            8'h00:                             item.kind = KIND_ZERO;
            default:                           item.kind = KIND_TEXT;
        endcase
    end

endmodule

// ----- src/lcm_fifo.sv -----
module lcm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- src/lcm_exec.sv -----
module lcm_exec #(
    parameter int LINE_MAX = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  lcm_pkg::item_t   item,
    output lcm_pkg::result_t result
);
    import lcm_pkg::*;

    localparam int CNT_W = $clog2(LINE_MAX);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [WORD_COUNT-1:0] mask_reg, mask_next;
    logic                  ended_reg, ended_next;
    logic [WORD_COUNT-1:0] len_hit;
    logic [WORD_COUNT-1:0] char_hit;
    logic [WORD_COUNT-1:0] final_mask;
    logic                  in_slots;

    assign in_slots = ({1'b0, count_reg} < (CNT_W + 1)'(WORD_SLOTS));

    always_comb
    begin
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            len_hit[i]  = (count_reg == CNT_W'(WORD_LEN[i]));
            char_hit[i] = in_slots && (count_reg < CNT_W'(WORD_LEN[i]))
                && (WORD_TEXT[i][count_reg[2:0]] == item.ch);
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        mask_next      = mask_reg;
        ended_next     = ended_reg;
        result.status  = ST_BUSY;
        result.command = '0;
        final_mask     = ended_reg ? mask_reg : (mask_reg & len_hit);
        unique case (item.kind)
            KIND_CR:
            begin
            end
            KIND_LF:
            begin
                result.status = ST_UNKNOWN;
                for (int i = WORD_COUNT - 1; i >= 0; i--)
                begin
                    if (final_mask[i])
                    begin
                        result.status  = ST_FRAME;
                        result.command = CMD_W'(i);
                    end
                end
                count_next = '0;
                mask_next  = '1;
                ended_next = 1'b0;
            end
            KIND_BLANK, KIND_ZERO, KIND_TEXT:
            begin
                if (item.kind == KIND_BLANK && count_reg == '0)
                begin
                end
                else if (count_reg != CNT_W'(LINE_MAX - 1))
                begin
                    if (!ended_reg)
                    begin
                        if (item.kind == KIND_ZERO)
                        begin
                            ended_next = 1'b1;
                            mask_next  = mask_reg & len_hit;
                        end
                        else
                        begin
                            mask_next = mask_reg & char_hit;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    count_next    = '0;
                    mask_next     = '1;
                    ended_next    = 1'b0;
                    result.status = ST_OVERFLOW;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mask_reg  <= '1;
            ended_reg <= 1'b0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
            mask_reg  <= mask_next;
            ended_reg <= ended_next;
        end
    end

endmodule

// ----- src/line_command_matcher.sv -----
// channel   dir  handshake         payload
// input     in   push / full       rx_byte[7:0]
// result    out  empty / pop       status[1:0], command[2:0]
//
// one beat in and one beat out per cycle, sustained while the result queue is not full
// an accepted byte is registered in the input queue; the line matcher then writes
// its result into the result queue, which drives the result ports
// reset clears both queues and the line state; nothing needs a clearing pass
// full rises once the input queue holds QUEUE_DEPTH beats; the matcher stalls
// while the result queue is full, so an unread result back-pressures the input
module line_command_matcher #(
    parameter int LINE_MAX    = 64,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] status,
    output logic [2:0] command
);
    import lcm_pkg::*;

    item_t   in_item;
    item_t   mid_item;
    result_t exec_result;
    result_t out_result;
    logic    mid_empty;
    logic    mid_full;
    logic    out_full;
    logic    exec_fire;

    assign full      = mid_full;
    assign exec_fire = !mid_empty && !out_full;
    assign status    = out_result.status;
    assign command   = out_result.command;

    lcm_classify u_classify (
        .rx_byte (rx_byte),
        .item    (in_item)
    );

    lcm_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_item),
        .full  (mid_full),
        .pop   (exec_fire),
        .rdata (mid_item),
        .empty (mid_empty)
    );

    lcm_exec #(
        .LINE_MAX (LINE_MAX)
    ) u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (exec_fire),
        .item   (mid_item),
        .result (exec_result)
    );

    lcm_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (exec_fire),
        .wdata (exec_result),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_result),
        .empty (empty)
    );

`include "line_command_matcher_assert.svh"

    `LCM_ASSERT_SAME(a_cmd_zero, !empty && status != ST_FRAME, command == '0, "stray command")
    `LCM_ASSERT_NEXT(a_mid_filled, push && !full, !mid_empty, "accepted beat not queued")
    `LCM_ASSERT_NEXT(a_out_filled, exec_fire, !empty, "matched beat not in result queue")

endmodule

// ----- verif/line_command_matcher_checker.sv -----
module line_command_matcher_checker #(
    parameter int LINE_MAX = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] rx_byte,
    input  logic       empty,
    input  logic       pop,
    input  logic [1:0] status,
    input  logic [2:0] command,
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import lcm_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VTAB  = 8'h0b;
    localparam logic [7:0] CH_FORM  = 8'h0c;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam int         SHOWN    = 10;

    string cmd_words [WORD_COUNT] = '{
        "led1on", "led1off", "led2on", "led2off", "allon", "alloff", "help", "dist?"
    };

    int         seen_len;
    logic [7:0] live_words;
    bit         text_cut;
    result_t    line_verdicts [$];

    function automatic void restart_line();
        seen_len   = 0;
        live_words = '1;
        text_cut   = 1'b0;
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] same_length(input logic [7:0] m, input int n);
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            if (cmd_words[i].len() != n)
            begin
                m[i] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic result_t judge_byte(input logic [7:0] b);
        result_t    r;
        logic [7:0] m;
        logic [7:0] fb;
        r.status  = ST_BUSY;
        r.command = '0;
        if (b == CH_CR)
        begin
            r.status = ST_BUSY;
        end
        else if (b == CH_LF)
        begin
            m = text_cut ? live_words : same_length(live_words, seen_len);
            r.status = ST_UNKNOWN;
            // lowest surviving word wins
            for (int i = WORD_COUNT - 1; i >= 0; i--)
            begin
                if (m[i])
                begin
                    r.status  = ST_FRAME;
                    r.command = 3'(i);
                end
            end
            restart_line();
        end
        else if (seen_len == 0 &&
                 (b == CH_SPACE || b == CH_TAB || b == CH_VTAB || b == CH_FORM))
        begin
            r.status = ST_BUSY;
        end
        else if (seen_len < LINE_MAX - 1)
        begin
            if (!text_cut)
            begin
                if (b == CH_NUL)
                begin
                    text_cut   = 1'b1;
                    live_words = same_length(live_words, seen_len);
                end
                else
                begin
                    fb = lower(b);
                    for (int i = 0; i < WORD_COUNT; i++)
                    begin
                        if (!(seen_len < cmd_words[i].len() && cmd_words[i][seen_len] == fb))
                        begin
                            live_words[i] = 1'b0;
                        end
                    end
                end
            end
            seen_len++;
        end
        else
        begin
            restart_line();
            r.status = ST_OVERFLOW;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            restart_line();
            line_verdicts.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (line_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN)
                    begin
                        $display("%0t: unexpected result beat status %0d command %0d",
                                 $time, status, command);
                    end
                end
                else
                begin
                    want = line_verdicts.pop_front();
                    if (status !== want.status || command !== want.command)
                    begin
                        mismatches++;
                        if (mismatches <= SHOWN)
                        begin
                            $display("%0t: status exp %0d got %0d, command exp %0d got %0d",
                                     $time, want.status, status, want.command, command);
                        end
                    end
                end
            end
            if (push && !full)
            begin
                line_verdicts.push_back(judge_byte(rx_byte));
            end
            outstanding = line_verdicts.size();
        end
    end

endmodule

// ----- verif/line_command_matcher_test.sv -----
module line_command_matcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcm_pkg::*;

    localparam int LINE_MAX      = 64;
    localparam int ITEM_TARGET   = 2000;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [7:0] BLANK_CHARS [4] = '{8'h20, 8'h09, 8'h0b, 8'h0c};

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] rx_byte;
    logic       empty;
    logic       pop;
    logic [1:0] status;
    logic [2:0] command;
    int         mismatches;
    int         outstanding;

    logic [7:0] tx_bytes [$];
    bit         tx_steady;
    bit         rx_steady;

    string spellings [8] = '{
        "led1on", "led1off", "led2on", "led2off", "allon", "alloff", "help", "dist?"
    };

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    line_command_matcher #(
        .LINE_MAX(LINE_MAX)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .rx_byte (rx_byte),
        .empty   (empty),
        .pop     (pop),
        .status  (status),
        .command (command)
    );

    line_command_matcher_checker #(
        .LINE_MAX(LINE_MAX)
    ) verdicts (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .rx_byte     (rx_byte),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .command     (command),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
        begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            tx_bytes.push_back(s[k]);
        end
    endfunction

    function automatic void add_random_line();
        logic [7:0] line [$];
        int         pick;
        int         w;
        int         n;
        pick = $urandom_range(0, 99);
        w    = $urandom_range(0, 7);
        if (pick < 60)
        begin
            // command word, possibly damaged
            repeat ($urandom_range(0, 2)) line.push_back(BLANK_CHARS[$urandom_range(0, 3)]);
            for (int k = 0; k < spellings[w].len(); k++)
            begin
                line.push_back(mixed_case(spellings[w][k]));
            end
            case ($urandom_range(0, 11))
                0: line.push_back(8'($urandom_range(33, 126)));
                1: void'(line.pop_back());
                2: line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
                3:
                begin
                    line.push_back(8'h00);
                    repeat ($urandom_range(0, 5)) line.push_back(8'($urandom_range(0, 255)));
                end
                4: line.insert($urandom_range(1, line.size() - 1), 8'h00);
                5: line.push_back(BLANK_CHARS[$urandom_range(0, 3)]);
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                line.insert($urandom_range(0, line.size()), CH_CR);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                line.push_back(CH_CR);
            end
        end
        else if (pick < 75)
        begin
            repeat ($urandom_range(0, 12)) line.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick < 83)
        begin
            repeat ($urandom_range(0, 3))
                line.push_back($urandom_range(0, 4) == 4 ? CH_CR : BLANK_CHARS[$urandom_range(0, 3)]);
        end
        else if (pick < 91)
        begin
            // around the overflow boundary
            n = $urandom_range(LINE_MAX - 3, LINE_MAX + 3);
            while (line.size() < n)
            begin
                line.push_back($urandom_range(0, 15) == 0 ? 8'h00 : 8'($urandom_range(32, 126)));
            end
        end
        else
        begin
            n = $urandom_range(1, spellings[w].len() - 1);
            for (int k = 0; k < n; k++)
            begin
                line.push_back(mixed_case(spellings[w][k]));
            end
        end
        line.push_back(CH_LF);
        tx_bytes = {tx_bytes, line};
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 31) == 0)
        begin
            tx_steady = !tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic drain_results();
        int gap;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                rx_steady = !rx_steady;
            end
            gap = rx_steady ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    endtask

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        rx_byte   = 8'h00;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // leading blanks, mixed case, carriage return
        add_text("\t LeD1oN\r\n");
        // zero byte ends the compared text, trailing byte still counted
        add_text("HELP");
        tx_bytes.push_back(8'h00);
        add_text("x\n");
        add_text("\n");
        tx_bytes.push_back(8'hff);
        add_text("\n");
        add_text("dIsT?\n");
        while (tx_bytes.size() < ITEM_TARGET)
        begin
            add_random_line();
        end

        fork
            drain_results();
        join_none

        while (tx_bytes.size() > 0)
        begin
            send_byte(tx_bytes.pop_front());
        end
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- line_command_matcher.f -----
+incdir+src
src/lcm_pkg.sv
src/lcm_classify.sv
src/lcm_fifo.sv
src/lcm_exec.sv
src/line_command_matcher.sv
verif/line_command_matcher_checker.sv
verif/line_command_matcher_test.sv
